// ===== rtl/core/cbpp_pkg.sv =====
// Shared constants, types and state codes for the cell bitmap plotter.
package cbpp_pkg;

  localparam int CELLS_ACROSS = 40;
  localparam int PIXEL_ROWS   = 200;

  localparam int SCREEN_COLS  = CELLS_ACROSS * 8;
  localparam int CELL_ROWS    = (PIXEL_ROWS + 7) / 8;
  localparam int CELL_COUNT   = CELL_ROWS * CELLS_ACROSS;
  localparam int BITMAP_BYTES = CELL_COUNT * 8;

  localparam int COL_W  = $clog2(SCREEN_COLS + 8);
  localparam int ROW_W  = $clog2(PIXEL_ROWS + 8);
  localparam int CELL_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int BYTE_W = CELL_W + 3;

  localparam logic [3:0] FORE_RESET = 4'd1;
  localparam logic [3:0] BACK_RESET = 4'd0;

  localparam logic [7:0] CFG_FORE = 8'd0;
  localparam logic [7:0] CFG_BACK = 8'd1;

  typedef enum logic [1:0] {
    REQ_SET   = 2'd0,
    REQ_GET   = 2'd1,
    REQ_LINE  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic              bm_we;
    logic [BYTE_W-1:0] bm_addr;
    logic [7:0]        bm_wdata;
    logic              cl_we;
    logic [CELL_W-1:0] cl_addr;
    logic [7:0]        cl_wdata;
  } store_req_t;

endpackage

// ===== rtl/core/cbpp_store.sv =====
// Bitmap byte memory and cell color memory, one port each, registered read.
module cbpp_store import cbpp_pkg::*; (
  input  logic       clk_i,
  input  store_req_t req_i,
  output logic [7:0] bm_rdata_o,
  output logic [7:0] cl_rdata_o
);

  logic [7:0] bitmap_mem [BITMAP_BYTES];
  logic [7:0] cell_mem   [CELL_COUNT];

  always_ff @(posedge clk_i) begin
    if (req_i.bm_we) begin
      bitmap_mem[req_i.bm_addr] <= req_i.bm_wdata;
    end
    bm_rdata_o <= bitmap_mem[req_i.bm_addr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.cl_we) begin
      cell_mem[req_i.cl_addr] <= req_i.cl_wdata;
    end
    cl_rdata_o <= cell_mem[req_i.cl_addr];
  end

endmodule

// ===== rtl/core/cbpp_ctrl.sv =====
// Request sequencer: clipping, pixel read-modify-write loop and memory sweep.
module cbpp_ctrl import cbpp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         req_type_i,
  input  logic signed [15:0] x_start_i,
  input  logic signed [15:0] x_end_i,
  input  logic signed [15:0] row_y_i,
  input  logic [3:0]         pen_color_i,
  input  logic [3:0]         fore_color_i,
  input  logic [3:0]         back_color_i,
  input  logic [7:0]         bm_rdata_i,
  input  logic [7:0]         cl_rdata_i,
  output store_req_t         store_o,
  output logic               busy_o,
  output logic               done_o,
  output logic [3:0]         pixel_color_o,
  output logic               in_range_o
);

  state_e state_q, state_d;
  req_e   req_q, req_d;
  logic [COL_W-1:0]  x_q, x_d, hi_q, hi_d;
  logic [ROW_W-1:0]  y_q, y_d;
  logic [3:0]        pen_q, pen_d;
  logic [BYTE_W-1:0] sweep_q, sweep_d;
  logic [7:0]        fill_q, fill_d;
  logic              done_q, done_d, hit_q, hit_d;
  logic [3:0]        color_q, color_d;

  logic signed [15:0] cols_s, rows_s, lo_s, hi_s;
  logic               x_ok, y_ok, line_ok, sweep_last, last_x;
  logic [CELL_W-1:0]  cell_addr;
  logic [7:0]         mask, cur_bits;
  logic               clear_bit;

  assign cols_s  = $signed(16'(SCREEN_COLS));
  assign rows_s  = $signed(16'(PIXEL_ROWS));
  assign x_ok    = (x_start_i >= 16'sd0) && (x_start_i < cols_s);
  assign y_ok    = (row_y_i >= 16'sd0) && (row_y_i < rows_s);
  assign lo_s    = (x_start_i < x_end_i) ? x_start_i : x_end_i;
  assign hi_s    = (x_start_i < x_end_i) ? x_end_i : x_start_i;
  assign line_ok = y_ok && (hi_s >= 16'sd0) && (lo_s < cols_s);

  assign sweep_last = (sweep_q == BYTE_W'(BITMAP_BYTES - 1));
  assign last_x     = (x_q == hi_q);

  assign cell_addr = CELL_W'(y_q[ROW_W-1:3]) * CELL_W'(CELLS_ACROSS)
                   + CELL_W'(x_q[COL_W-1:3]);
  assign mask      = 8'h80 >> x_q[2:0];
  assign cur_bits  = bm_rdata_i & mask;
  assign clear_bit = (pen_q == cl_rdata_i[3:0]);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT:   if (sweep_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (start_i) begin
          unique case (req_e'(req_type_i))
            REQ_SET, REQ_GET: if (x_ok && y_ok) state_d = ST_READ;
            REQ_LINE:         if (line_ok) state_d = ST_READ;
            REQ_CLEAR:        state_d = ST_CLEAR;
            default:          state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ:   state_d = ST_MODIFY;
      ST_MODIFY: begin
        if (req_q == REQ_LINE && !last_x) state_d = ST_READ;
        else                              state_d = ST_IDLE;
      end
      ST_CLEAR:  if (sweep_last) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    req_d   = req_q;
    x_d     = x_q;
    hi_d    = hi_q;
    y_d     = y_q;
    pen_d   = pen_q;
    sweep_d = sweep_q;
    fill_d  = fill_q;
    done_d  = 1'b0;
    hit_d   = 1'b0;
    color_d = 4'd0;
    store_o = '0;
    store_o.bm_addr = {cell_addr, y_q[2:0]};
    store_o.cl_addr = cell_addr;
    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        store_o.bm_we    = 1'b1;
        store_o.bm_addr  = sweep_q;
        store_o.bm_wdata = 8'd0;
        store_o.cl_we    = 1'b1;
        store_o.cl_addr  = sweep_q[BYTE_W-1:3];
        store_o.cl_wdata = fill_q;
        sweep_d          = sweep_q + 1'b1;
        if (sweep_last && state_q == ST_CLEAR) begin
          done_d = 1'b1;
          hit_d  = 1'b1;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          req_d   = req_e'(req_type_i);
          pen_d   = pen_color_i;
          y_d     = row_y_i[ROW_W-1:0];
          sweep_d = '0;
          fill_d  = {fore_color_i, back_color_i};
          if (req_e'(req_type_i) == REQ_LINE) begin
            x_d  = (lo_s < 16'sd0) ? '0 : lo_s[COL_W-1:0];
            hi_d = (hi_s >= cols_s) ? COL_W'(SCREEN_COLS - 1) : hi_s[COL_W-1:0];
            done_d = !line_ok;
          end else if (req_e'(req_type_i) != REQ_CLEAR) begin
            x_d    = x_start_i[COL_W-1:0];
            done_d = !(x_ok && y_ok);
          end
        end
      end
      ST_READ: ;
      ST_MODIFY: begin
        if (req_q == REQ_GET) begin
          color_d = (cur_bits != 8'd0) ? cl_rdata_i[7:4] : cl_rdata_i[3:0];
        end else begin
          store_o.bm_we = 1'b1;
          if (clear_bit) begin
            store_o.bm_wdata = bm_rdata_i & ~mask;
          end else begin
            store_o.bm_wdata = bm_rdata_i | mask;
            store_o.cl_we    = 1'b1;
            store_o.cl_wdata = {pen_q, cl_rdata_i[3:0]};
          end
        end
        if (req_q == REQ_LINE && !last_x) begin
          x_d = x_q + 1'b1;
        end else begin
          done_d = 1'b1;
          hit_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      sweep_q <= '0;
      fill_q  <= 8'd0;
      done_q  <= 1'b0;
      hit_q   <= 1'b0;
      color_q <= 4'd0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      fill_q  <= fill_d;
      done_q  <= done_d;
      hit_q   <= hit_d;
      color_q <= color_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    x_q   <= x_d;
    hi_q  <= hi_d;
    y_q   <= y_d;
    pen_q <= pen_d;
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign in_range_o    = hit_q;
  assign pixel_color_o = color_q;

endmodule

// ===== rtl/core/cell_bitmap_pixel_plotter.sv =====
// Top level of the cell-layout bitmap pixel plotter.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  request  | start_i, busy_o        | req_type_i x_start_i x_end_i row_y_i pen_color_i
//  result   | done_o (one-cycle)     | pixel_color_o in_range_o
//  config   | cfg_valid_i/cfg_ready_o| cfg_index_i cfg_data_i
//
// Set/get go from accept to done_o through the read state, the modify state
// and the result register; a line repeats read and modify for each clipped
// pixel, then the result register; clear writes one bitmap byte per cycle
// on the single memory port across all BITMAP_BYTES, then the result
// register. Clipped requests report on the next cycle.
// After reset the block sweeps both memories to zero with busy_o high. The
// receiver cannot stall; a result is valid for one cycle.
module cell_bitmap_pixel_plotter import cbpp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [15:0] x_start_i,
  input  logic signed [15:0] x_end_i,
  input  logic signed [15:0] row_y_i,
  input  logic [3:0]         pen_color_i,
  output logic               done_o,
  output logic [3:0]         pixel_color_o,
  output logic               in_range_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [3:0]         cfg_data_i
);

  logic [3:0] fore_q, back_q;
  store_req_t store_req;
  logic [7:0] bm_rdata, cl_rdata;

  // config registers are always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fore_q <= FORE_RESET;
      back_q <= BACK_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_FORE) fore_q <= cfg_data_i;
      if (cfg_index_i == CFG_BACK) back_q <= cfg_data_i;
    end
  end

  cbpp_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i,
    .req_type_i,
    .x_start_i,
    .x_end_i,
    .row_y_i,
    .pen_color_i,
    .fore_color_i (fore_q),
    .back_color_i (back_q),
    .bm_rdata_i   (bm_rdata),
    .cl_rdata_i   (cl_rdata),
    .store_o      (store_req),
    .busy_o,
    .done_o,
    .pixel_color_o,
    .in_range_o
  );

  cbpp_store u_store (
    .clk_i,
    .req_i      (store_req),
    .bm_rdata_o (bm_rdata),
    .cl_rdata_o (cl_rdata)
  );

  // a result always leaves the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("result while busy");
  // result fields are zero outside the strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_range_o |-> done_o)
    else $error("in_range without result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_color_o != 4'd0) |-> (done_o && in_range_o))
    else $error("color on clipped or absent result");

endmodule
